### hw/rtl/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Shared widths, constants and types of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbpe_pkg;

   localparam int T_FRAC_BITS = 16;
   localparam int T_W         = 17;
   localparam int COORD_W     = 32;
   localparam int W_W         = T_FRAC_BITS + 1;
   localparam int SQ_W        = 2 * W_W;
   localparam int TRI_W       = SQ_W + 2;
   localparam int PROD_W      = W_W + COORD_W;
   localparam int ACC_W       = PROD_W + 2;
   localparam int RND_W       = ACC_W - T_FRAC_BITS;

   localparam logic [T_W-1:0]   T_ONE    = T_W'(2 ** T_FRAC_BITS);
   localparam logic [W_W-1:0]   W_ONE    = W_W'(2 ** T_FRAC_BITS);
   localparam logic [SQ_W-1:0]  SQ_HALF  = SQ_W'(2 ** (T_FRAC_BITS - 1));
   localparam logic [TRI_W-1:0] TRI_HALF = TRI_W'(2 ** (T_FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(2 ** (T_FRAC_BITS - 1));

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } cbpe_adv_type;

   typedef struct packed {
      logic [W_W-1:0] w0;
      logic [W_W-1:0] w1;
      logic [W_W-1:0] w2;
      logic [W_W-1:0] w3;
   } cbpe_weights_type;

endpackage

### hw/rtl/cbpe_weight_gen.sv
// ----------------------------------------------------------------------------
// cbpe_weight_gen
// Two-stage Bernstein weight generator: clamp and squares, then the four
// rounded cubic weights.
// ----------------------------------------------------------------------------
module cbpe_weight_gen (
   input  logic                        clock,
   input  cbpe_pkg::cbpe_adv_type      adv,
   input  logic [cbpe_pkg::T_W-1:0]    param_t,
   output cbpe_pkg::cbpe_weights_type  weights
);

   logic [cbpe_pkg::W_W-1:0]   tc_in, tc_ff, uc_in, uc_ff;
   logic [cbpe_pkg::W_W-1:0]   st_in, st_ff, su_in, su_ff;
   logic [cbpe_pkg::SQ_W-1:0]  sq_t, sq_u;
   logic [cbpe_pkg::SQ_W-1:0]  p0, p1, p2, p3;
   logic [cbpe_pkg::TRI_W-1:0] tri_w1, tri_w2;
   cbpe_pkg::cbpe_weights_type w_in, w_ff;

   // stage 1: clamp t, form t^2 and (1-t)^2
   always_comb begin
      if (param_t > cbpe_pkg::T_ONE) begin
         tc_in = cbpe_pkg::W_ONE;
      end else begin
         tc_in = cbpe_pkg::W_W'(param_t);
      end
      uc_in = cbpe_pkg::W_ONE - tc_in;
      sq_t  = cbpe_pkg::SQ_W'(tc_in) * cbpe_pkg::SQ_W'(tc_in) + cbpe_pkg::SQ_HALF;
      sq_u  = cbpe_pkg::SQ_W'(uc_in) * cbpe_pkg::SQ_W'(uc_in) + cbpe_pkg::SQ_HALF;
      st_in = cbpe_pkg::W_W'(sq_t >> cbpe_pkg::T_FRAC_BITS);
      su_in = cbpe_pkg::W_W'(sq_u >> cbpe_pkg::T_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         tc_ff <= tc_in;
         uc_ff <= uc_in;
         st_ff <= st_in;
         su_ff <= su_in;
      end
   end

   // stage 2: cubic weights
   always_comb begin
      p0     = cbpe_pkg::SQ_W'(su_ff) * cbpe_pkg::SQ_W'(uc_ff);
      p1     = cbpe_pkg::SQ_W'(tc_ff) * cbpe_pkg::SQ_W'(su_ff);
      p2     = cbpe_pkg::SQ_W'(st_ff) * cbpe_pkg::SQ_W'(uc_ff);
      p3     = cbpe_pkg::SQ_W'(st_ff) * cbpe_pkg::SQ_W'(tc_ff);
      tri_w1 = (cbpe_pkg::TRI_W'(p1) << 1) + cbpe_pkg::TRI_W'(p1) + cbpe_pkg::TRI_HALF;
      tri_w2 = (cbpe_pkg::TRI_W'(p2) << 1) + cbpe_pkg::TRI_W'(p2) + cbpe_pkg::TRI_HALF;
      w_in.w0 = cbpe_pkg::W_W'((p0 + cbpe_pkg::SQ_HALF) >> cbpe_pkg::T_FRAC_BITS);
      w_in.w1 = cbpe_pkg::W_W'(tri_w1 >> cbpe_pkg::T_FRAC_BITS);
      w_in.w2 = cbpe_pkg::W_W'(tri_w2 >> cbpe_pkg::T_FRAC_BITS);
      w_in.w3 = cbpe_pkg::W_W'((p3 + cbpe_pkg::SQ_HALF) >> cbpe_pkg::T_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         w_ff <= w_in;
      end
   end

   assign weights = w_ff;

endmodule

### hw/rtl/cbpe_combine.sv
// ----------------------------------------------------------------------------
// cbpe_combine
// One coordinate lane: delays the control points, forms the four weighted
// products, then sums, rounds and saturates.
// ----------------------------------------------------------------------------
module cbpe_combine (
   input  logic                                clock,
   input  cbpe_pkg::cbpe_adv_type              adv,
   input  logic signed [cbpe_pkg::COORD_W-1:0] pt0,
   input  logic signed [cbpe_pkg::COORD_W-1:0] pt1,
   input  logic signed [cbpe_pkg::COORD_W-1:0] pt2,
   input  logic signed [cbpe_pkg::COORD_W-1:0] pt3,
   input  cbpe_pkg::cbpe_weights_type          weights,
   output logic signed [cbpe_pkg::COORD_W-1:0] result
);

   logic signed [cbpe_pkg::COORD_W-1:0] s1_pt_ff [4];
   logic signed [cbpe_pkg::COORD_W-1:0] s2_pt_ff [4];
   logic signed [cbpe_pkg::PROD_W:0]    full [4];
   logic [cbpe_pkg::W_W-1:0]            w [4];
   logic signed [cbpe_pkg::PROD_W-1:0]  prod_in [4];
   logic signed [cbpe_pkg::PROD_W-1:0]  prod_ff [4];
   logic signed [cbpe_pkg::ACC_W-1:0]   acc;
   logic signed [cbpe_pkg::RND_W-1:0]   rnd;
   logic signed [cbpe_pkg::COORD_W-1:0] res_in, res_ff;

   // stages 1 and 2: hold the points alongside the weights
   always_ff @(posedge clock) begin
      if (adv.s1) begin
         s1_pt_ff[0] <= pt0;
         s1_pt_ff[1] <= pt1;
         s1_pt_ff[2] <= pt2;
         s1_pt_ff[3] <= pt3;
      end
      if (adv.s2) begin
         s2_pt_ff <= s1_pt_ff;
      end
   end

   // stage 3: weighted products
   always_comb begin
      w[0] = weights.w0;
      w[1] = weights.w1;
      w[2] = weights.w2;
      w[3] = weights.w3;
      for (int k = 0; k < 4; k++) begin
         full[k]    = $signed({1'b0, w[k]}) * s2_pt_ff[k];
         prod_in[k] = full[k][cbpe_pkg::PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         prod_ff <= prod_in;
      end
   end

   // stage 4: sum, round half up, saturate
   always_comb begin
      acc = cbpe_pkg::ACC_HALF;
      for (int k = 0; k < 4; k++) begin
         acc = acc + {{2{prod_ff[k][cbpe_pkg::PROD_W-1]}}, prod_ff[k]};
      end
      rnd = acc[cbpe_pkg::ACC_W-1:cbpe_pkg::T_FRAC_BITS];
      if (rnd > cbpe_pkg::RND_W'(cbpe_pkg::COORD_MAX)) begin
         res_in = cbpe_pkg::COORD_MAX;
      end else if (rnd < cbpe_pkg::RND_W'(cbpe_pkg::COORD_MIN)) begin
         res_in = cbpe_pkg::COORD_MIN;
      end else begin
         res_in = rnd[cbpe_pkg::COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

### hw/rtl/cubic_bezier_point_eval_unit.sv
// Stages: four register stages; a response is valid once its request, after
// being accepted, has been registered in each of them.
// Throughput: one transaction per cycle while rsp_ready is high; each stage
// advances if empty or if its successor does; a stall holds it without loss.
// Reset: synchronous, active high; clears the stage valid bits only.
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval_unit
// Four-stage pipelined evaluator of one point on a 2D cubic Bezier curve.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cbpe_pkg::T_W-1:0]            req_param_t,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point0_x,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point0_y,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point1_x,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point1_y,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point2_x,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point2_y,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point3_x,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point3_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cbpe_pkg::COORD_W-1:0] rsp_curve_x,
   output logic signed [cbpe_pkg::COORD_W-1:0] rsp_curve_y
);

   logic [3:0]                 vld_in, vld_ff;
   cbpe_pkg::cbpe_adv_type     adv;
   cbpe_pkg::cbpe_weights_type weights;

   // advance a stage when it is empty or its content moves on
   always_comb begin
      adv.s4 = !vld_ff[3] || rsp_ready;
      adv.s3 = !vld_ff[2] || adv.s4;
      adv.s2 = !vld_ff[1] || adv.s3;
      adv.s1 = !vld_ff[0] || adv.s2;
      vld_in[0] = adv.s1 ? req_valid : vld_ff[0];
      vld_in[1] = adv.s2 ? vld_ff[0] : vld_ff[1];
      vld_in[2] = adv.s3 ? vld_ff[1] : vld_ff[2];
      vld_in[3] = adv.s4 ? vld_ff[2] : vld_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv.s1;
   assign rsp_valid = vld_ff[3];

   cbpe_weight_gen u_weight_gen (
      .clock   (clock),
      .adv     (adv),
      .param_t (req_param_t),
      .weights (weights)
   );

   cbpe_combine u_combine_x (
      .clock   (clock),
      .adv     (adv),
      .pt0     (req_point0_x),
      .pt1     (req_point1_x),
      .pt2     (req_point2_x),
      .pt3     (req_point3_x),
      .weights (weights),
      .result  (rsp_curve_x)
   );

   cbpe_combine u_combine_y (
      .clock   (clock),
      .adv     (adv),
      .pt0     (req_point0_y),
      .pt1     (req_point1_y),
      .pt2     (req_point2_y),
      .pt3     (req_point3_y),
      .weights (weights),
      .result  (rsp_curve_y)
   );

endmodule

### sim/cbpe_point_checker.sv
// ----------------------------------------------------------------------------
// cbpe_point_checker
// Watches the request and response channels of the cubic Bezier point
// evaluator. Every accepted request is turned into an expected curve point by
// an independent fixed point model: Bernstein weights rounded to the t format,
// a weighted sum of the control points, rounding and saturation. Every
// accepted response is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module cbpe_point_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [cbpe_pkg::T_W-1:0]            req_param_t,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point0_x,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point0_y,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point1_x,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point1_y,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point2_x,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point2_y,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point3_x,
   input  logic signed [cbpe_pkg::COORD_W-1:0] req_point3_y,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [cbpe_pkg::COORD_W-1:0] rsp_curve_x,
   input  logic signed [cbpe_pkg::COORD_W-1:0] rsp_curve_y,
   output int                                  mismatch_count,
   output int                                  points_in_flight
);

   localparam int     FRAC     = cbpe_pkg::T_FRAC_BITS;
   localparam longint UNIT     = longint'(1) << FRAC;
   localparam longint HALF_LSB = longint'(1) << (FRAC - 1);

   typedef struct packed {
      logic signed [cbpe_pkg::COORD_W-1:0] x;
      logic signed [cbpe_pkg::COORD_W-1:0] y;
   } curve_point_type;

   curve_point_type expected_points[$];

   function automatic void bernstein_weights(
      input  logic [cbpe_pkg::T_W-1:0] t_raw,
      output longint w0,
      output longint w1,
      output longint w2,
      output longint w3
   );
      longint tc;
      longint uc;
      longint t_sq;
      longint u_sq;
      tc   = (longint'(t_raw) > UNIT) ? UNIT : longint'(t_raw);
      uc   = UNIT - tc;
      t_sq = (tc * tc + HALF_LSB) >> FRAC;
      u_sq = (uc * uc + HALF_LSB) >> FRAC;
      w0   = (u_sq * uc + HALF_LSB) >> FRAC;
      w1   = (3 * tc * u_sq + HALF_LSB) >> FRAC;
      w2   = (3 * t_sq * uc + HALF_LSB) >> FRAC;
      w3   = (t_sq * tc + HALF_LSB) >> FRAC;
   endfunction

   function automatic logic signed [cbpe_pkg::COORD_W-1:0] blend_coord(
      input longint w0,
      input longint w1,
      input longint w2,
      input longint w3,
      input logic signed [cbpe_pkg::COORD_W-1:0] c0,
      input logic signed [cbpe_pkg::COORD_W-1:0] c1,
      input logic signed [cbpe_pkg::COORD_W-1:0] c2,
      input logic signed [cbpe_pkg::COORD_W-1:0] c3
   );
      longint acc;
      acc = w0 * longint'(c0) + w1 * longint'(c1) + w2 * longint'(c2) + w3 * longint'(c3);
      acc = (acc + HALF_LSB) >>> FRAC;
      if (acc > longint'(cbpe_pkg::COORD_MAX))
         return cbpe_pkg::COORD_MAX;
      if (acc < longint'(cbpe_pkg::COORD_MIN))
         return cbpe_pkg::COORD_MIN;
      return acc[cbpe_pkg::COORD_W-1:0];
   endfunction

   always @(posedge clock) begin
      curve_point_type due;
      longint          w0;
      longint          w1;
      longint          w2;
      longint          w3;
      if (reset) begin
         expected_points.delete();
      end else begin
         if (req_valid && req_ready) begin
            bernstein_weights(req_param_t, w0, w1, w2, w3);
            due.x = blend_coord(w0, w1, w2, w3, req_point0_x, req_point1_x,
                                req_point2_x, req_point3_x);
            due.y = blend_coord(w0, w1, w2, w3, req_point0_y, req_point1_y,
                                req_point2_y, req_point3_y);
            expected_points.push_back(due);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected transaction: curve_x %0d curve_y %0d",
                      rsp_curve_x, rsp_curve_y);
               mismatch_count++;
            end else begin
               due = expected_points.pop_front();
               if (rsp_curve_x !== due.x) begin
                  $error("curve_x: expected %0d, got %0d", due.x, rsp_curve_x);
                  mismatch_count++;
               end
               if (rsp_curve_y !== due.y) begin
                  $error("curve_y: expected %0d, got %0d", due.y, rsp_curve_y);
                  mismatch_count++;
               end
            end
         end
      end
      points_in_flight <= expected_points.size();
   end

endmodule

### sim/tb_cubic_bezier_point_eval_unit.sv
// ----------------------------------------------------------------------------
// tb_cubic_bezier_point_eval_unit
// Drives control points and curve parameters into the evaluator: a directed
// set of end points, clamped and extreme parameters and saturating sums, then
// random curves with random gaps and response stalls, including a long
// hold-off that fills the pipeline. The checker module judges every result.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_point_eval_unit;

   localparam int RANDOM_CURVES = 700;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 12;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [cbpe_pkg::T_W-1:0]            req_param_t;
   logic signed [cbpe_pkg::COORD_W-1:0] req_point0_x;
   logic signed [cbpe_pkg::COORD_W-1:0] req_point0_y;
   logic signed [cbpe_pkg::COORD_W-1:0] req_point1_x;
   logic signed [cbpe_pkg::COORD_W-1:0] req_point1_y;
   logic signed [cbpe_pkg::COORD_W-1:0] req_point2_x;
   logic signed [cbpe_pkg::COORD_W-1:0] req_point2_y;
   logic signed [cbpe_pkg::COORD_W-1:0] req_point3_x;
   logic signed [cbpe_pkg::COORD_W-1:0] req_point3_y;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [cbpe_pkg::COORD_W-1:0] rsp_curve_x;
   logic signed [cbpe_pkg::COORD_W-1:0] rsp_curve_y;
   int                                  mismatch_count;
   int                                  points_in_flight;
   int                                  idle_cycles;

   cubic_bezier_point_eval_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_param_t  (req_param_t),
      .req_point0_x (req_point0_x),
      .req_point0_y (req_point0_y),
      .req_point1_x (req_point1_x),
      .req_point1_y (req_point1_y),
      .req_point2_x (req_point2_x),
      .req_point2_y (req_point2_y),
      .req_point3_x (req_point3_x),
      .req_point3_y (req_point3_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_curve_x  (rsp_curve_x),
      .rsp_curve_y  (rsp_curve_y)
   );

   cbpe_point_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_param_t      (req_param_t),
      .req_point0_x     (req_point0_x),
      .req_point0_y     (req_point0_y),
      .req_point1_x     (req_point1_x),
      .req_point1_y     (req_point1_y),
      .req_point2_x     (req_point2_x),
      .req_point2_y     (req_point2_y),
      .req_point3_x     (req_point3_x),
      .req_point3_y     (req_point3_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_curve_x      (rsp_curve_x),
      .rsp_curve_y      (rsp_curve_y),
      .mismatch_count   (mismatch_count),
      .points_in_flight (points_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hold valid across back-to-back transactions; drop it only for a gap
   task automatic send_curve(
      input int                                  gap,
      input logic [cbpe_pkg::T_W-1:0]            t,
      input logic signed [cbpe_pkg::COORD_W-1:0] p0x,
      input logic signed [cbpe_pkg::COORD_W-1:0] p0y,
      input logic signed [cbpe_pkg::COORD_W-1:0] p1x,
      input logic signed [cbpe_pkg::COORD_W-1:0] p1y,
      input logic signed [cbpe_pkg::COORD_W-1:0] p2x,
      input logic signed [cbpe_pkg::COORD_W-1:0] p2y,
      input logic signed [cbpe_pkg::COORD_W-1:0] p3x,
      input logic signed [cbpe_pkg::COORD_W-1:0] p3y
   );
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_param_t  <= t;
      req_point0_x <= p0x;
      req_point0_y <= p0y;
      req_point1_x <= p1x;
      req_point1_y <= p1y;
      req_point2_x <= p2x;
      req_point2_y <= p2y;
      req_point3_x <= p3x;
      req_point3_y <= p3y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic int pick_gap(input bit burst);
      int r;
      r = $urandom_range(0, 19);
      if (burst || r < 10)
         return 0;
      if (r < 18)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [cbpe_pkg::T_W-1:0] pick_param();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return cbpe_pkg::T_ONE;
      if (r < 4)
         return cbpe_pkg::T_W'($urandom_range(0, (1 << cbpe_pkg::T_W) - 1));
      return cbpe_pkg::T_W'($urandom_range(0, int'(cbpe_pkg::T_ONE)));
   endfunction

   function automatic logic signed [cbpe_pkg::COORD_W-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         5, 6: return cbpe_pkg::COORD_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         7: return cbpe_pkg::COORD_MAX - cbpe_pkg::COORD_W'($urandom_range(0, 255));
         8: return cbpe_pkg::COORD_MIN + cbpe_pkg::COORD_W'($urandom_range(0, 255));
         9: return cbpe_pkg::COORD_W'($signed($urandom_range(0, 2)) - 1);
         default: return cbpe_pkg::COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [cbpe_pkg::COORD_W-1:0] near_rail(input bit high);
      if (high)
         return cbpe_pkg::COORD_MAX - cbpe_pkg::COORD_W'($urandom_range(0, 4095));
      return cbpe_pkg::COORD_MIN + cbpe_pkg::COORD_W'($urandom_range(0, 4095));
   endfunction

   // long hold-off first so the pipeline fills and stalls the request side
   initial begin
      int len;
      int r;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      repeat (12) @(posedge clock);
      rsp_ready <= 1'b0;
      repeat (120) @(posedge clock);
      forever begin
         r = $urandom_range(0, 19);
         if (r < 6) begin
            rsp_ready <= 1'b1;
            len = $urandom_range(20, 60);
         end else if (r < 18) begin
            rsp_ready <= 1'($urandom_range(0, 1));
            len = $urandom_range(1, 4);
         end else begin
            rsp_ready <= 1'b0;
            len = $urandom_range(20, 50);
         end
         repeat (len) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL cubic_bezier_point_eval_unit");
         $finish;
      end
   end

   initial begin
      bit  burst;
      bit  rail;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_param_t  <= '0;
      req_point0_x <= '0;
      req_point0_y <= '0;
      req_point1_x <= '0;
      req_point1_y <= '0;
      req_point2_x <= '0;
      req_point2_y <= '0;
      req_point3_x <= '0;
      req_point3_y <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // end points, clamped parameters, rails, saturation, bit patterns
      send_curve(0, '0, 32'sd12345, -32'sd777, 32'sd5, 32'sd6, 32'sd7, 32'sd8,
                 -32'sd9, 32'sd10);
      send_curve(0, cbpe_pkg::T_ONE, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6,
                 -32'sd424242, 32'sd99999);
      send_curve(0, cbpe_pkg::T_W'(cbpe_pkg::T_ONE + 1), cbpe_pkg::COORD_MIN,
                 cbpe_pkg::COORD_MAX, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1000,
                 -32'sd1000);
      send_curve(0, '1, 32'sd0, 32'sd0, cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN,
                 32'sd0, 32'sd0, cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN);
      send_curve(0, cbpe_pkg::T_W'(32768),
                 cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MAX,
                 cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN,
                 cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN);
      send_curve(0, cbpe_pkg::T_W'(21845),
                 cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MAX,
                 cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MAX,
                 cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MAX);
      send_curve(0, cbpe_pkg::T_W'(43691),
                 cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MIN,
                 cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MIN,
                 cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MIN);
      send_curve(0, cbpe_pkg::T_W'(1),
                 cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MAX,
                 cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN,
                 cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN);
      send_curve(0, cbpe_pkg::T_W'(cbpe_pkg::T_ONE - 1),
                 cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN,
                 cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MAX,
                 cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN);
      send_curve(0, '0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                 32'sd0, 32'sd0);
      send_curve(0, cbpe_pkg::T_W'(32768), 32'sd1, -32'sd1, 32'sd1, -32'sd1, 32'sd1,
                 -32'sd1, 32'sd1, -32'sd1);
      send_curve(0, cbpe_pkg::T_W'(32768), 32'sd0, 32'sd0, 32'sd1, -32'sd1, 32'sd0,
                 32'sd0, 32'sd0, 32'sd0);
      send_curve(0, cbpe_pkg::T_W'(16384), 32'shAAAAAAAA, 32'sh55555555,
                 32'sh55555555, 32'shAAAAAAAA, 32'shAAAAAAAA, 32'sh55555555,
                 32'sh55555555, 32'shAAAAAAAA);
      send_curve(0, cbpe_pkg::T_W'(49152), 32'sh55555555, 32'shAAAAAAAA,
                 32'shAAAAAAAA, 32'sh55555555, 32'sh55555555, 32'shAAAAAAAA,
                 32'shAAAAAAAA, 32'sh55555555);
      send_curve(0, cbpe_pkg::T_W'(65535), -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                 -32'sd1, -32'sd1, -32'sd1, -32'sd1);
      send_curve(0, cbpe_pkg::T_W'(10923),
                 cbpe_pkg::COORD_MAX - 1, cbpe_pkg::COORD_MIN + 1, cbpe_pkg::COORD_MAX,
                 cbpe_pkg::COORD_MIN, cbpe_pkg::COORD_MAX, cbpe_pkg::COORD_MIN,
                 cbpe_pkg::COORD_MAX - 1, cbpe_pkg::COORD_MIN + 1);
      send_curve(0, cbpe_pkg::T_W'(98304), 32'sd3, 32'sd4, 32'sd5, 32'sd6, 32'sd7,
                 32'sd8, -32'sd65536, 32'sd65536);

      burst = 1'b0;
      for (int n = 0; n < RANDOM_CURVES; n++) begin
         if (n % 50 == 0)
            burst = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 7) == 0) begin
            rail = 1'($urandom_range(0, 1));
            send_curve(pick_gap(burst), cbpe_pkg::T_W'($urandom_range(8192, 57344)),
                       near_rail(rail), near_rail(!rail), near_rail(rail),
                       near_rail(!rail), near_rail(rail), near_rail(!rail),
                       near_rail(rail), near_rail(!rail));
         end else begin
            send_curve(pick_gap(burst), pick_param(), pick_coord(), pick_coord(),
                       pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                       pick_coord(), pick_coord());
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (points_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && points_in_flight == 0) begin
         $display("PASS cubic_bezier_point_eval_unit");
      end else begin
         $display("FAIL cubic_bezier_point_eval_unit");
      end
      $finish;
   end

endmodule
